FILE: rtl/smpq_pkg.sv
`timescale 1ns / 1ps

package smpq_pkg;

   localparam int DEPTH   = 16;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;
   localparam int PRIO_W  = 16;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_PEEK   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic signed [PRIO_W-1:0]  prio;
   } entry_type;

   // Broadcast to every cell in the row for one item.
   typedef struct packed {
      logic      ins;
      logic      rem;
      entry_type fresh;
   } cell_op_type;

endpackage

FILE: rtl/smpq_cell.sv
`timescale 1ns / 1ps

module smpq_cell (
   input  logic                clock,
   input  smpq_pkg::cell_op_type op,
   input  logic                occupied,
   input  logic                left_keep,
   input  smpq_pkg::entry_type left_entry,
   input  smpq_pkg::entry_type right_entry,
   output logic                keep,
   output smpq_pkg::entry_type entry
);
   import smpq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // An occupied entry whose priority is not above the new one stays put,
   // which keeps equal priorities in arrival order.
   assign keep  = occupied && ($signed(entry_ff.prio) <= $signed(op.fresh.prio));
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (op.ins) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (left_keep) begin
            entry_in = op.fresh;
         end else begin
            entry_in = left_entry;
         end
      end else if (op.rem) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: rtl/stable_min_priority_queue.sv
`timescale 1ns / 1ps

// Sorted priority queue of DEPTH entries built as a row of cells, head in the
// first cell. For each item (insert, remove or peek) all cells compare against
// the new priority and shift in parallel, so a new item is taken in every
// cycle in which the result register is empty or its item is being taken.
// The result is registered and appears in the cycle after acceptance.
// Equal priorities leave in arrival order; a refused insert reports full and
// a remove or peek of an empty queue reports empty, leaving the contents alone.
module stable_min_priority_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_kind,
   input  logic signed [smpq_pkg::VALUE_W-1:0]  req_item_value,
   input  logic signed [smpq_pkg::PRIO_W-1:0]   req_item_priority,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [smpq_pkg::VALUE_W-1:0]  rsp_head_value,
   output logic [1:0]                           rsp_status,
   output logic [smpq_pkg::COUNT_W-1:0]         rsp_occupancy
);
   import smpq_pkg::*;

   logic                      req_fire;
   logic [COUNT_W-1:0]        count_ff;
   logic [COUNT_W-1:0]        count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_head_value_ff;
   logic signed [VALUE_W-1:0] rsp_head_value_in;
   status_type                rsp_status_ff;
   status_type                rsp_status_in;
   logic [COUNT_W-1:0]        rsp_occupancy_ff;
   cell_op_type               op;
   logic                      is_full;
   logic                      is_empty;
   logic [DEPTH-1:0]          occupied;
   logic [DEPTH-1:0]          keep;
   entry_type                 entries [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_full   = (count_ff == COUNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);

   always_comb begin
      op.ins            = 1'b0;
      op.rem            = 1'b0;
      op.fresh.value    = req_item_value;
      op.fresh.prio     = req_item_priority;
      count_in          = count_ff;
      rsp_head_value_in = '0;
      rsp_status_in     = STATUS_OK;
      case (kind_type'(req_kind))
         KIND_INSERT: begin
            if (is_full) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               op.ins   = req_fire;
               count_in = count_ff + COUNT_W'(1);
            end
         end
         KIND_REMOVE: begin
            if (is_empty) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               op.rem            = req_fire;
               rsp_head_value_in = entries[0].value;
               count_in          = count_ff - COUNT_W'(1);
            end
         end
         KIND_PEEK: begin
            if (is_empty) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               rsp_head_value_in = entries[0].value;
            end
         end
         default: begin
            rsp_status_in = STATUS_OK;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign occupied[i] = (COUNT_W'(i) < count_ff);
      if (i == 0) begin : g_head
         smpq_cell u_cell (
            .clock       (clock),
            .op          (op),
            .occupied    (occupied[i]),
            .left_keep   (1'b1),
            .left_entry  (entries[i]),
            .right_entry (entries[i+1]),
            .keep        (keep[i]),
            .entry       (entries[i])
         );
      end else if (i == DEPTH - 1) begin : g_tail
         smpq_cell u_cell (
            .clock       (clock),
            .op          (op),
            .occupied    (occupied[i]),
            .left_keep   (keep[i-1]),
            .left_entry  (entries[i-1]),
            .right_entry (entries[i]),
            .keep        (keep[i]),
            .entry       (entries[i])
         );
      end else begin : g_mid
         smpq_cell u_cell (
            .clock       (clock),
            .op          (op),
            .occupied    (occupied[i]),
            .left_keep   (keep[i-1]),
            .left_entry  (entries[i-1]),
            .right_entry (entries[i+1]),
            .keep        (keep[i]),
            .entry       (entries[i])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_head_value_ff <= rsp_head_value_in;
         rsp_status_ff     <= rsp_status_in;
         rsp_occupancy_ff  <= count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_head_value = rsp_head_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_occupancy  = rsp_occupancy_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("entry count exceeds depth");

   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      (req_fire && kind_type'(req_kind) == KIND_INSERT && !is_full)
      |=> count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("accepted insert did not add an entry");

   a_occupancy_matches : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_occupancy_ff == count_ff)
      else $error("reported occupancy differs from entry count");

   a_head_sorted : assert property (@(posedge clock) disable iff (reset)
      (count_ff >= COUNT_W'(2))
      |-> $signed(entries[0].prio) <= $signed(entries[1].prio))
      else $error("head entry out of order");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import smpq_pkg::*;

   localparam logic [1:0] KIND_NOP = 2'd3;
   localparam int RANDOM_ITEMS = 930;
   localparam int LONG_HOLD = 64;

   typedef struct packed {
      logic signed [VALUE_W-1:0] head_value;
      status_type                status;
      logic [COUNT_W-1:0]        occupancy;
   } answer_type;

   typedef struct {
      logic [1:0]               kind;
      logic signed [VALUE_W-1:0] value;
      logic signed [PRIO_W-1:0]  prio;
      int                        reps;
      bit                        typed;
      answer_type                known;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_kind = KIND_NOP;
   logic signed [VALUE_W-1:0] req_item_value = '0;
   logic signed [PRIO_W-1:0] req_item_priority = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0] rsp_head_value;
   logic [1:0] rsp_status;
   logic [COUNT_W-1:0] rsp_occupancy;

   // Travels with the item: a hand-written answer for the directed rows.
   logic req_typed = 1'b0;
   answer_type typed_answer = '0;

   logic signed [VALUE_W-1:0] held_value[$];
   logic signed [PRIO_W-1:0] held_prio[$];
   answer_type awaited_answers[$];
   int failures = 0;

   int rsp_mode = 1;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int rsp_cycle = 0;

   stable_min_priority_queue dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_head_value    (rsp_head_value),
      .rsp_status        (rsp_status),
      .rsp_occupancy     (rsp_occupancy)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Sorted-list queue: an insert goes behind every entry of lower or equal priority.
   function automatic answer_type queue_step(input logic [1:0] kind,
                                             input logic signed [VALUE_W-1:0] value,
                                             input logic signed [PRIO_W-1:0] prio);
      answer_type answer;
      int pos;
      answer = '0;
      answer.status = STATUS_OK;
      case (kind)
         KIND_INSERT: begin
            if (held_value.size() >= DEPTH) begin
               answer.status = STATUS_FULL;
            end else begin
               pos = 0;
               while (pos < held_prio.size() && held_prio[pos] <= prio)
                  pos++;
               held_value.insert(pos, value);
               held_prio.insert(pos, prio);
            end
         end
         KIND_REMOVE, KIND_PEEK: begin
            if (held_value.size() == 0) begin
               answer.status = STATUS_EMPTY;
            end else begin
               answer.head_value = held_value[0];
               if (kind == KIND_REMOVE) begin
                  void'(held_value.pop_front());
                  void'(held_prio.pop_front());
               end
            end
         end
         default: ;
      endcase
      answer.occupancy = COUNT_W'(held_value.size());
      return answer;
   endfunction

   always @(posedge clock) begin
      answer_type expected;
      answer_type predicted;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_answers.size() == 0) begin
               $display("%0t: result item with none expected: head_value %0d status %0d",
                        $time, rsp_head_value, rsp_status);
               failures++;
            end else begin
               expected = awaited_answers.pop_front();
               if (rsp_head_value !== expected.head_value) begin
                  $display("%0t: head_value expected %0d, actual %0d",
                           $time, expected.head_value, rsp_head_value);
                  failures++;
               end
               if (rsp_status !== expected.status) begin
                  $display("%0t: status expected %0d, actual %0d",
                           $time, expected.status, rsp_status);
                  failures++;
               end
               if (rsp_occupancy !== expected.occupancy) begin
                  $display("%0t: occupancy expected %0d, actual %0d",
                           $time, expected.occupancy, rsp_occupancy);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predicted = queue_step(req_kind, req_item_value, req_item_priority);
            awaited_answers.push_back(req_typed ? typed_answer : predicted);
         end
      end
   end

   // Receiver: a stall pattern chosen per phase, with occasional long hold-offs.
   always @(posedge clock) begin
      rsp_cycle <= rsp_cycle + 1;
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_mode != 0 && $urandom_range(511) == 0) begin
         hold_left <= $urandom_range(20, 50);
         rsp_ready <= 1'b0;
      end else begin
         case (rsp_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(3) != 0);
            2: rsp_ready <= ($urandom_range(1) != 0);
            default: rsp_ready <= ((rsp_cycle % 7) < 3);
         endcase
      end
   end

   task automatic offer_item(input logic [1:0] kind,
                             input logic signed [VALUE_W-1:0] value,
                             input logic signed [PRIO_W-1:0] prio,
                             input bit typed,
                             input answer_type known);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_item_value <= value;
      req_item_priority <= prio;
      req_typed <= typed;
      typed_answer <= known;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   initial begin
      stim_row_type directed_rows[19];
      int sent;
      int burst_left;
      int gap;
      int max_gap;
      int insert_pct;
      int prio_mode;
      int phase;
      int phase_items;
      int pick;
      logic [1:0] kind;
      logic signed [PRIO_W-1:0] prio;

      directed_rows = '{
         '{KIND_PEEK,   32'sd0,            16'sd0,      1,  1'b1, '{32'sd0, STATUS_EMPTY, 5'd0}},
         '{KIND_REMOVE, 32'sd0,            16'sd0,      1,  1'b1, '{32'sd0, STATUS_EMPTY, 5'd0}},
         '{KIND_NOP,    32'sd7,            16'sd7,      1,  1'b1, '{32'sd0, STATUS_OK, 5'd0}},
         '{KIND_INSERT, 32'sh7FFF_FFFF,    16'sh7FFF,   1,  1'b1, '{32'sd0, STATUS_OK, 5'd1}},
         '{KIND_INSERT, 32'sh8000_0000,    16'sh8000,   1,  1'b1, '{32'sd0, STATUS_OK, 5'd2}},
         '{KIND_PEEK,   32'sd0,            16'sd0,      1,  1'b1,
           '{32'sh8000_0000, STATUS_OK, 5'd2}},
         '{KIND_INSERT, 32'sd5,            16'sd0,      1,  1'b0, '0},
         '{KIND_INSERT, 32'sd6,            16'sd0,      1,  1'b0, '0},
         '{KIND_INSERT, -32'sd1,           -16'sd1,     1,  1'b0, '0},
         '{KIND_NOP,    32'sd0,            16'sd0,      1,  1'b0, '0},
         '{KIND_REMOVE, 32'sd0,            16'sd0,      1,  1'b1,
           '{32'sh8000_0000, STATUS_OK, 5'd4}},
         '{KIND_REMOVE, 32'sd0,            16'sd0,      3,  1'b0, '0},
         '{KIND_REMOVE, 32'sd0,            16'sd0,      1,  1'b1,
           '{32'sh7FFF_FFFF, STATUS_OK, 5'd0}},
         '{KIND_INSERT, 32'sd100,          16'sd10,     16, 1'b0, '0},
         '{KIND_INSERT, -32'sd1,           16'sd0,      1,  1'b1, '{32'sd0, STATUS_FULL, 5'd16}},
         '{KIND_PEEK,   32'sd0,            16'sd0,      1,  1'b0, '0},
         '{KIND_NOP,    32'sd0,            16'sd0,      1,  1'b1, '{32'sd0, STATUS_OK, 5'd16}},
         '{KIND_REMOVE, 32'sd0,            16'sd0,      16, 1'b0, '0},
         '{KIND_REMOVE, 32'sd0,            16'sd0,      1,  1'b1, '{32'sd0, STATUS_EMPTY, 5'd0}}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Repeated inserts step the value up and the priority down, so each new
      // entry goes in at the head and the row of cells shifts toward the far end.
      foreach (directed_rows[r])
         for (int i = 0; i < directed_rows[r].reps; i++)
            offer_item(directed_rows[r].kind, directed_rows[r].value + i,
                       directed_rows[r].prio - PRIO_W'(i),
                       directed_rows[r].typed, directed_rows[r].known);

      sent = 0;
      phase = 0;
      burst_left = 0;
      while (sent < RANDOM_ITEMS) begin
         phase_items = $urandom_range(40, 120);
         pick = $urandom_range(4);
         insert_pct = (pick == 0) ? 85 : (pick == 1) ? 20 : (pick == 2) ? 50 :
                      (pick == 3) ? 65 : 35;
         prio_mode = $urandom_range(2);
         pick = $urandom_range(2);
         max_gap = (pick == 0) ? 0 : (pick == 1) ? 3 : 8;
         rsp_mode = $urandom_range(3);
         // A long hold-off while the sender keeps offering leaves the result register full, so requests stall.
         if (phase % 4 == 1) begin
            insert_pct = 85;
            max_gap = 0;
            hold_token = hold_token + 1;
         end
         for (int n = 0; n < phase_items && sent < RANDOM_ITEMS; n++) begin
            if (burst_left == 0) begin
               gap = $urandom_range(0, max_gap);
               if (gap != 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
               burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            if ($urandom_range(99) < insert_pct) begin
               kind = KIND_INSERT;
            end else begin
               pick = $urandom_range(9);
               kind = (pick == 0) ? KIND_NOP : (pick <= 3) ? KIND_PEEK : KIND_REMOVE;
            end
            case (prio_mode)
               0: prio = PRIO_W'($urandom_range(0, 65535));
               1: prio = PRIO_W'($urandom_range(0, 6)) - 16'sd3;
               default: begin
                  pick = $urandom_range(5);
                  prio = (pick == 0) ? 16'sh8000 : (pick == 1) ? 16'sh8001 :
                         (pick == 2) ? -16'sd1 : (pick == 3) ? 16'sd0 :
                         (pick == 4) ? 16'sh7FFE : 16'sh7FFF;
               end
            endcase
            offer_item(kind, $urandom(), prio, 1'b0, '0);
            sent++;
         end
         phase++;
      end

      req_valid <= 1'b0;
      rsp_mode = 0;
      // Let the checker record the last accepted item before the awaited answers are drained.
      @(posedge clock);
      while (awaited_answers.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
